// ===== rtl/core/mvs_pkg.sv =====
package mvs_pkg;

  localparam int ROWS     = 4;
  localparam int COLS     = 1024;
  localparam int KEY_BITS = 32;
  localparam int COL_W    = $clog2(COLS);
  localparam int ENT_W    = 32 + KEY_BITS + 31;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EXEC
  } state_t;

  // controller commands to datapath
  typedef struct packed {
    logic clr_en;
    logic [COL_W-1:0] clr_addr;
    logic latch;
    logic rd_en;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic is_query;
  } stat_t;

endpackage

// ===== rtl/core/mvs_ctrl.sv =====
module mvs_ctrl import mvs_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  output logic  busy,
  output cmd_t  cmd,
  input  stat_t stat
);

  state_t st_r, st_nxt;
  logic [COL_W:0] cnt_r, cnt_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_CLEAR;
      cnt_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // next state and commands
  always_comb begin
    st_nxt = st_r;
    cnt_nxt = cnt_r;
    cmd = '0;
    cmd.clr_addr = cnt_r[COL_W-1:0];
    busy = 1'b1;
    case (st_r)
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == (COL_W+1)'(COLS-1)) st_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.latch = 1'b1;
          st_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        st_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  logic unused_q;
  assign unused_q = stat.is_query;

endmodule

// ===== rtl/core/mvs_dp.sv =====
module mvs_dp import mvs_pkg::*; (
  input  logic        clk,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic        in_opcode,
  input  logic [31:0] in_flow_key,
  input  logic signed [31:0] in_increment,
  input  logic [9:0]  in_col_row0,
  input  logic [9:0]  in_col_row1,
  input  logic [9:0]  in_col_row2,
  input  logic [9:0]  in_col_row3,
  output logic        out_valid,
  output logic [31:0] out_estimate
);

  logic                op_r;
  logic [KEY_BITS-1:0] key_r;
  logic [31:0]         inc_r;
  logic [COL_W-1:0]    col_r [ROWS];
  logic [ENT_W-1:0]    rd_r  [ROWS];
  logic [ENT_W-1:0]    mem   [ROWS][COLS];
  logic [9:0]          cin   [4];
  logic [ENT_W-1:0]    wr    [ROWS];
  logic [32:0]         est   [ROWS];
  logic [32:0]         best;
  logic                upd_ok;

  assign cin[0] = in_col_row0;
  assign cin[1] = in_col_row1;
  assign cin[2] = in_col_row2;
  assign cin[3] = in_col_row3;
  assign stat.is_query = op_r;
  assign upd_ok = (inc_r != '0) && !inc_r[31];

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r  <= in_opcode;
      key_r <= KEY_BITS'(in_flow_key);
      inc_r <= in_increment;
      for (int r = 0; r < ROWS; r++) col_r[r] <= COL_W'(cin[r] % COLS);
    end
  end

  // per-row bucket update and estimate
  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      logic [31:0] tot;
      logic [KEY_BITS-1:0] cand;
      logic [30:0] vote;
      logic [32:0] s;
      logic [32:0] v;
      tot  = rd_r[r][ENT_W-1 -: 32];
      cand = rd_r[r][30+KEY_BITS -: KEY_BITS];
      vote = rd_r[r][30:0];
      s = {1'b0, tot} + {1'b0, inc_r};
      wr[r][ENT_W-1 -: 32] = s[32] ? 32'hFFFFFFFF : s[31:0];
      wr[r][30+KEY_BITS -: KEY_BITS] = cand;
      if (cand == key_r) begin
        v = {2'b0, vote} + {1'b0, inc_r};
        wr[r][30:0] = (v > 33'h07FFFFFFF) ? 31'h7FFFFFFF : v[30:0];
      end else if (inc_r > {1'b0, vote}) begin
        v = {1'b0, inc_r} - {2'b0, vote};
        wr[r][30+KEY_BITS -: KEY_BITS] = key_r;
        wr[r][30:0] = (v > 33'h07FFFFFFF) ? 31'h7FFFFFFF : v[30:0];
      end else begin
        v = {1'b0, inc_r} - {2'b0, vote};
        wr[r][30:0] = vote - inc_r[30:0];
      end
      if (cand == key_r) est[r] = ({1'b0, tot} + {2'b0, vote}) >> 1;
      else if (tot >= {1'b0, vote}) est[r] = ({1'b0, tot} - {2'b0, vote}) >> 1;
      else est[r] = '0;
    end
    best = est[0];
    for (int r = 1; r < ROWS; r++) if (est[r] < best) best = est[r];
  end

  // row memories
  always_ff @(posedge clk) begin
    for (int r = 0; r < ROWS; r++) begin
      if (cmd.clr_en) mem[r][cmd.clr_addr] <= '0;
      else if (cmd.exec && !op_r && upd_ok) mem[r][col_r[r]] <= wr[r];
      if (cmd.rd_en) rd_r[r] <= mem[r][col_r[r]];
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    out_valid    <= cmd.exec && op_r;
    out_estimate <= best[32] ? 32'hFFFFFFFF : best[31:0];
  end

endmodule

// ===== rtl/core/majority_vote_flow_sketch_core.sv =====
// mv-sketch heavy-hitter tracker, four rows of 1024 buckets
// input: start with busy low transfers one item (opcode, key, increment,
// one column per row). opcode 0 updates, opcode 1 queries.
// an item passes capture, row memory read, then update or estimate;
// busy is high for the read and execute steps, so a new item is taken only
// once the read-modify-write of the last one through each row memory is done.
// a query raises out_valid from the result register after its row read, for one
// cycle, with out_estimate; updates give no result.
// the receiver cannot stall: each result stands one cycle only.
// after reset a clearing pass over all 1024 columns zeroes all buckets, busy high.
module majority_vote_flow_sketch_core import mvs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_opcode,
  input  logic [31:0] in_flow_key,
  input  logic signed [31:0] in_increment,
  input  logic [9:0]  in_col_row0,
  input  logic [9:0]  in_col_row1,
  input  logic [9:0]  in_col_row2,
  input  logic [9:0]  in_col_row3,
  output logic        out_valid,
  output logic [31:0] out_estimate
);

  cmd_t  cmd;
  stat_t stat;
  logic  vld;

  mvs_ctrl u_ctrl (.clk, .rst_n, .start, .busy, .cmd, .stat);

  mvs_dp u_dp (
    .clk, .cmd, .stat, .in_opcode, .in_flow_key, .in_increment,
    .in_col_row0, .in_col_row1, .in_col_row2, .in_col_row3,
    .out_valid(vld), .out_estimate
  );

  assign out_valid = vld & rst_n;

endmodule

// ===== test/mv_sketch_checker.sv =====
module mv_sketch_checker import mvs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_opcode,
  input  logic [31:0] in_flow_key,
  input  logic [31:0] in_increment,
  input  logic [9:0]  in_col_row0,
  input  logic [9:0]  in_col_row1,
  input  logic [9:0]  in_col_row2,
  input  logic [9:0]  in_col_row3,
  input  logic        out_valid,
  input  logic [31:0] out_estimate,
  output int          err_count,
  output int          est_pending,
  output int          est_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [33:0] TOT_SAT  = 34'h0_ffff_ffff;
  localparam logic [33:0] VOTE_SAT = 34'h0_7fff_ffff;

  // local copy of the bucket arrays
  logic [31:0] tot_mem  [ROWS][COLS];
  logic [31:0] cand_mem [ROWS][COLS];
  logic [30:0] vote_mem [ROWS][COLS];

  logic [31:0] est_queue [$];

  initial begin
    err_count = 0;
    est_checked = 0;
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLS; c++) begin
        tot_mem[r][c] = '0;
        cand_mem[r][c] = '0;
        vote_mem[r][c] = '0;
      end
    end
  end

  assign est_pending = est_queue.size();

  // apply one accepted transfer, queue the estimate for queries
  task automatic apply_item(logic op, logic [31:0] key, logic [31:0] inc,
                            logic [9:0] cols [ROWS]);
    logic [33:0] t, v, s, best, e;
    begin
      if (op == OP_QUERY) begin
        best = 34'h3_ffff_ffff;
        for (int r = 0; r < ROWS; r++) begin
          t = {2'b0, tot_mem[r][cols[r]]};
          v = {3'b0, vote_mem[r][cols[r]]};
          if (cand_mem[r][cols[r]] == key) e = (t + v) >> 1;
          else if (t >= v) e = (t - v) >> 1;
          else e = '0;
          if (e < best) best = e;
        end
        if (best > TOT_SAT) best = TOT_SAT;
        est_queue.push_back(best[31:0]);
      end else if (inc != 0 && !inc[31]) begin
        for (int r = 0; r < ROWS; r++) begin
          t = {2'b0, tot_mem[r][cols[r]]};
          v = {3'b0, vote_mem[r][cols[r]]};
          s = t + {2'b0, inc};
          if (s > TOT_SAT) s = TOT_SAT;
          tot_mem[r][cols[r]] = s[31:0];
          if (cand_mem[r][cols[r]] == key) begin
            s = v + {2'b0, inc};
            if (s > VOTE_SAT) s = VOTE_SAT;
          end else if ({2'b0, inc} > v) begin
            s = {2'b0, inc} - v;
            if (s > VOTE_SAT) s = VOTE_SAT;
            cand_mem[r][cols[r]] = key;
          end else begin
            s = v - {2'b0, inc};
          end
          vote_mem[r][cols[r]] = s[30:0];
        end
      end
    end
  endtask

  // watch both channels at each edge
  always @(posedge clk) begin
    logic [9:0] cols [ROWS];
    logic [31:0] exp_est;
    if (rst_n) begin
      if (out_valid) begin
        if (est_queue.size() == 0) begin
          $error("estimate with no query waiting: actual %0d", out_estimate);
          err_count++;
        end else begin
          exp_est = est_queue.pop_front();
          est_checked++;
          if (out_estimate !== exp_est) begin
            $error("estimate mismatch: expected %0d actual %0d", exp_est, out_estimate);
            err_count++;
          end
        end
      end
      if (start && !busy) begin
        cols[0] = in_col_row0;
        cols[1] = in_col_row1;
        cols[2] = in_col_row2;
        cols[3] = in_col_row3;
        apply_item(in_opcode, in_flow_key, in_increment, cols);
      end
    end
  end
endmodule

// ===== test/majority_vote_flow_sketch_core_tb.sv =====
module majority_vote_flow_sketch_core_tb import mvs_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_opcode;
  logic [31:0] in_flow_key;
  logic signed [31:0] in_increment;
  logic [9:0]  in_col_row0, in_col_row1, in_col_row2, in_col_row3;
  logic        out_valid;
  logic [31:0] out_estimate;
  int          err_count, est_pending, est_checked;
  int          n_sent;
  bit          no_idle;

  majority_vote_flow_sketch_core u_dut (
    .clk, .rst_n, .start, .busy, .in_opcode, .in_flow_key, .in_increment,
    .in_col_row0, .in_col_row1, .in_col_row2, .in_col_row3,
    .out_valid, .out_estimate
  );

  mv_sketch_checker u_chk (
    .clk, .rst_n, .start, .busy, .in_opcode, .in_flow_key,
    .in_increment(in_increment), .in_col_row0, .in_col_row1, .in_col_row2,
    .in_col_row3, .out_valid, .out_estimate,
    .err_count, .est_pending, .est_checked
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // overall limit
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // one transfer, then an occasional idle cycle
  task automatic send(logic op, logic [31:0] key, logic [31:0] inc,
                      logic [9:0] c0, logic [9:0] c1, logic [9:0] c2, logic [9:0] c3);
    begin
      start <= 1'b1;
      in_opcode <= op;
      in_flow_key <= key;
      in_increment <= inc;
      in_col_row0 <= c0;
      in_col_row1 <= c1;
      in_col_row2 <= c2;
      in_col_row3 <= c3;
      @(posedge clk);
      while (busy) @(posedge clk);
      n_sent++;
      if (!no_idle && $urandom_range(0, 99) < 6) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  // column drawn mostly from a small set so buckets collide
  function automatic logic [9:0] pick_col();
    if ($urandom_range(0, 3) == 0) return 10'($urandom);
    return 10'($urandom_range(0, 7)) | ($urandom_range(0, 1) ? 10'h3f8 : 10'h0);
  endfunction

  function automatic logic [31:0] pick_inc();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'h8000_0000 | $urandom;
      2:       return 32'h7fff_ffff - $urandom_range(0, 3);
      3:       return $urandom & 32'h7fff_ffff;
      default: return $urandom_range(1, 20);
    endcase
  endfunction

  initial begin
    logic [31:0] keys [4];
    logic [9:0] c [4];
    start = 1'b0;
    in_opcode = OP_UPDATE;
    in_flow_key = '0;
    in_increment = '0;
    in_col_row0 = '0;
    in_col_row1 = '0;
    in_col_row2 = '0;
    in_col_row3 = '0;
    n_sent = 0;
    no_idle = 1'b0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed: empty bucket, match, takeover, vote to zero, ignored, saturation
    send(OP_QUERY,  32'h0,         32'd0,         0, 0, 0, 0);
    send(OP_QUERY,  32'hffff_ffff, 32'd0,         10'h3ff, 10'h3ff, 10'h3ff, 10'h3ff);
    send(OP_UPDATE, 32'ha,         32'd1,         0, 0, 0, 0);
    send(OP_QUERY,  32'ha,         32'd0,         0, 0, 0, 0);
    send(OP_UPDATE, 32'hb,         32'd5,         0, 0, 0, 0);
    send(OP_QUERY,  32'ha,         32'd0,         0, 0, 0, 0);
    send(OP_QUERY,  32'hb,         32'd0,         0, 0, 0, 0);
    send(OP_UPDATE, 32'ha,         32'd4,         0, 0, 0, 0);
    send(OP_QUERY,  32'ha,         32'd0,         0, 0, 0, 0);
    send(OP_QUERY,  32'hb,         32'd0,         0, 0, 0, 0);
    send(OP_UPDATE, 32'ha,         32'd0,         0, 0, 0, 0);
    send(OP_UPDATE, 32'ha,         32'h8000_0000, 0, 0, 0, 0);
    send(OP_UPDATE, 32'ha,         32'hffff_ffff, 0, 0, 0, 0);
    send(OP_QUERY,  32'ha,         32'd0,         0, 0, 0, 0);
    send(OP_UPDATE, 32'hffff_ffff, 32'h7fff_ffff, 10'h3ff, 10'h3ff, 10'h3ff, 10'h3ff);
    send(OP_UPDATE, 32'hffff_ffff, 32'h7fff_ffff, 10'h3ff, 10'h3ff, 10'h3ff, 10'h3ff);
    send(OP_UPDATE, 32'hffff_ffff, 32'h7fff_ffff, 10'h3ff, 10'h3ff, 10'h3ff, 10'h3ff);
    send(OP_QUERY,  32'hffff_ffff, 32'd0,         10'h3ff, 10'h3ff, 10'h3ff, 10'h3ff);
    send(OP_UPDATE, 32'h0,         32'h7fff_ffff, 10'h3ff, 10'h3ff, 10'h3ff, 10'h3ff);
    send(OP_QUERY,  32'h0,         32'd0,         10'h3ff, 10'h3ff, 10'h3ff, 10'h3ff);
    send(OP_QUERY,  32'hffff_ffff, 32'd0,         10'h3ff, 10'h3ff, 10'h3ff, 10'h3ff);
    send(OP_UPDATE, 32'h5,         32'd7,         10'h155, 10'h2aa, 10'h0f0, 10'h30f);
    send(OP_QUERY,  32'h5,         32'd0,         10'h155, 10'h2aa, 10'h0f0, 10'h30f);

    // hold off until every estimate is back
    start <= 1'b0;
    @(posedge clk);
    wait (est_pending == 0);
    @(posedge clk);

    // random: a few heavy keys among noise, with an idle-free middle stretch
    for (int k = 0; k < 4; k++) keys[k] = $urandom;
    for (int i = 0; i < 400; i++) begin
      logic [31:0] key;
      no_idle = (i >= 150 && i < 250);
      key = ($urandom_range(0, 3) == 0) ? $urandom : keys[$urandom_range(0, 3)];
      for (int r = 0; r < 4; r++) c[r] = pick_col();
      if ($urandom_range(0, 99) < 35)
        send(OP_QUERY, key, $urandom, c[0], c[1], c[2], c[3]);
      else
        send(OP_UPDATE, key, pick_inc(), c[0], c[1], c[2], c[3]);
    end
    start <= 1'b0;

    // drain
    @(posedge clk);
    wait (est_pending == 0);
    repeat (10) @(posedge clk);
    $display("sent %0d items, %0d query estimates compared", n_sent, est_checked);
    $display("covered matches, takeovers, ignored increments and saturation");
    if (err_count == 0 && est_pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
